// ===== design/mcsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcsp_pkg
// Shared types, constants and helpers of the music command stream player.
// ----------------------------------------------------------------------------
package mcsp_pkg;

   // Song memory: indexed by the low SONG_AW bits of a 16-bit address.
   localparam int SONG_AW    = 16;
   localparam int SONG_DEPTH = 2 ** SONG_AW;

   // Write cap per tick and the result buffer that holds one tick's writes.
   localparam int MAX_WRITES = 63;
   localparam int WCNT_W     = $clog2(MAX_WRITES + 1);
   localparam int BUF_DEPTH  = 2 ** WCNT_W;

   // Commands fetched per tick before decoding pauses.
   localparam int CMD_BUDGET = 256;
   localparam int BUDGET_W   = $clog2(CMD_BUDGET + 1);

   typedef logic [SONG_AW-1:0] song_addr_type;

   // Request command codes.
   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   // Song byte codes.
   localparam logic [7:0] EXT_CODE   = 8'h40;
   localparam logic [7:0] END_CODE   = 8'h80;
   localparam logic [7:0] LEN_MASK   = 8'h3F;
   localparam logic [7:0] DELAY_MASK = 8'h7F;

   // Fixed addresses of the song header.
   localparam logic [15:0] START_PTR     = 16'd16;
   localparam logic [15:0] LOOP_ADDR_LO  = 16'd3;
   localparam logic [15:0] LOOP_ADDR_MID = 16'd4;
   localparam logic [15:0] LOOP_ADDR_HI  = 16'd5;

   localparam logic [7:0] LOOP_COUNT_RESET = 8'd2;

   typedef enum logic [2:0] {
      OPC_PSG   = 3'd0,
      OPC_EXT   = 3'd1,
      OPC_YM    = 3'd2,
      OPC_END   = 3'd3,
      OPC_DELAY = 3'd4
   } op_class_type;

   typedef enum logic [2:0] {
      RD_PTR   = 3'd0,
      RD_PTR1  = 3'd1,
      RD_LOOP0 = 3'd2,
      RD_LOOP1 = 3'd3,
      RD_LOOP2 = 3'd4
   } rd_sel_type;

   typedef enum logic [2:0] {
      PTR_HOLD    = 3'd0,
      PTR_ADD1    = 3'd1,
      PTR_ADD2    = 3'd2,
      PTR_ADD_EXT = 3'd3,
      PTR_LOOP    = 3'd4
   } ptr_op_type;

   typedef struct packed {
      logic         load_wr;
      logic         start_play;
      logic         tick_init;
      logic         delay_dec;
      logic         budget_dec;
      rd_sel_type   rd_sel;
      logic         op_latch;
      ptr_op_type   ptr_op;
      logic         ym_load;
      logic         ym_dec;
      logic         push;
      logic         push_ym;
      logic         loops_dec;
      logic         lb0_latch;
      logic         lb1_latch;
      logic         delay_set;
      logic         delay_clear;
      logic         pause;
      logic         finish;
      logic         fin_latch;
      logic         drain_init;
      logic         drain_issue;
      logic         stat_issue;
   } ctrl_cmd_type;

   typedef struct packed {
      logic         resume;
      logic         delay_zero;
      logic         delay_one;
      logic         ym_zero;
      logic         budget_zero;
      logic         writes_full;
      op_class_type op_class;
      logic         loops_zero;
      logic         laddr_zero;
      logic         count_zero;
      logic         drain_last;
   } dp_status_type;

   function automatic op_class_type classify(input logic [7:0] b);
      op_class_type c;
      priority if (b < EXT_CODE) begin
         c = OPC_PSG;
      end else if (b == EXT_CODE) begin
         c = OPC_EXT;
      end else if (b < END_CODE) begin
         c = OPC_YM;
      end else if (b == END_CODE) begin
         c = OPC_END;
      end else begin
         c = OPC_DELAY;
      end
      return c;
   endfunction

   function automatic song_addr_type song_index(input logic [15:0] a);
      return song_addr_type'(32'(a));
   endfunction

endpackage

// ===== design/mcsp_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcsp_dpath
// Datapath: song memory, playback registers, write buffer and result port.
// ----------------------------------------------------------------------------
module mcsp_dpath (
   input  logic                   clock,
   input  logic                   reset,
   input  mcsp_pkg::ctrl_cmd_type cmd,
   output mcsp_pkg::dp_status_type status,
   input  logic [15:0]            req_address,
   input  logic [7:0]             req_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [7:0]             csr_loop_count,
   output logic                   rsp_strobe,
   output logic                   rsp_write_valid,
   output logic                   rsp_chip,
   output logic [7:0]             rsp_reg_index,
   output logic [7:0]             rsp_reg_value,
   output logic                   rsp_playing,
   output logic                   rsp_more_pending,
   output logic                   rsp_last
);
   import mcsp_pkg::*;

   typedef struct packed {
      logic       chip;
      logic [7:0] reg_index;
      logic [7:0] reg_value;
   } buf_entry_type;

   logic [7:0]          song_mem [SONG_DEPTH];
   song_addr_type       rd_addr;
   logic [7:0]          mem_q_ff;

   buf_entry_type       buf_mem [BUF_DEPTH];
   buf_entry_type       buf_q_ff;

   logic [15:0]         rp_ff, rp_in;
   logic [6:0]          delay_ff, delay_in;
   logic [7:0]          loops_ff, loops_in;
   logic                resume_ff, resume_in;
   logic [5:0]          ym_ff, ym_in;
   logic [7:0]          loop_count_ff, loop_count_in;
   logic [WCNT_W-1:0]   wcnt_ff, wcnt_in;
   logic [BUDGET_W-1:0] budget_ff, budget_in;
   logic                paused_ff, paused_in;
   logic [WCNT_W-1:0]   drain_ff, drain_in;
   logic                s1_write_ff, s1_stat_ff;
   logic                strobe_ff;
   logic                playing_ff, more_ff;
   logic [7:0]          op_ff, lb0_ff, lb1_ff;
   logic                wv_ff, chip_ff, last_ff, rsp_playing_ff, rsp_more_ff;
   logic [7:0]          reg_index_ff, reg_value_ff;
   logic [15:0]         ext_step;

   // Song memory: one write port for loads, one registered read port.
   always_comb begin
      unique case (cmd.rd_sel)
         RD_PTR:   rd_addr = song_index(rp_ff);
         RD_PTR1:  rd_addr = song_index(rp_ff + 16'd1);
         RD_LOOP0: rd_addr = song_index(LOOP_ADDR_LO);
         RD_LOOP1: rd_addr = song_index(LOOP_ADDR_MID);
         RD_LOOP2: rd_addr = song_index(LOOP_ADDR_HI);
         default:  rd_addr = song_index(rp_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load_wr) begin
         song_mem[song_index(req_address)] <= req_data;
      end
      mem_q_ff <= song_mem[rd_addr];
   end

   // The writes of one tick are held here until its final status is known.
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         buf_mem[wcnt_ff] <= '{chip: cmd.push_ym, reg_index: op_ff, reg_value: mem_q_ff};
      end
      buf_q_ff <= buf_mem[drain_ff];
   end

   assign ext_step = 16'd2 + {8'd0, mem_q_ff & LEN_MASK};

   always_comb begin
      rp_in         = rp_ff;
      delay_in      = delay_ff;
      loops_in      = loops_ff;
      resume_in     = resume_ff;
      ym_in         = ym_ff;
      loop_count_in = loop_count_ff;
      wcnt_in       = wcnt_ff;
      budget_in     = budget_ff;
      paused_in     = paused_ff;
      drain_in      = drain_ff;

      if (csr_valid) begin
         loop_count_in = csr_loop_count;
      end

      unique case (cmd.ptr_op)
         PTR_HOLD:    rp_in = rp_ff;
         PTR_ADD1:    rp_in = rp_ff + 16'd1;
         PTR_ADD2:    rp_in = rp_ff + 16'd2;
         PTR_ADD_EXT: rp_in = rp_ff + ext_step;
         PTR_LOOP:    rp_in = {lb1_ff, lb0_ff};
         default:     rp_in = rp_ff;
      endcase

      if (cmd.delay_dec) begin
         delay_in = delay_ff - 7'd1;
      end
      if (cmd.delay_set) begin
         delay_in = mem_q_ff[6:0] & DELAY_MASK[6:0];
      end
      if (cmd.delay_clear) begin
         delay_in = 7'd0;
      end
      if (cmd.loops_dec) begin
         loops_in = loops_ff - 8'd1;
      end
      if (cmd.pause) begin
         resume_in = 1'b1;
         paused_in = 1'b1;
      end
      if (cmd.finish) begin
         resume_in = 1'b0;
      end
      if (cmd.ym_load) begin
         ym_in = mem_q_ff[5:0] & LEN_MASK[5:0];
      end
      if (cmd.ym_dec) begin
         ym_in = ym_ff - 6'd1;
      end
      if (cmd.tick_init) begin
         wcnt_in   = '0;
         budget_in = BUDGET_W'(CMD_BUDGET);
         paused_in = 1'b0;
      end
      if (cmd.push) begin
         wcnt_in = wcnt_ff + WCNT_W'(1);
      end
      if (cmd.budget_dec) begin
         budget_in = budget_ff - BUDGET_W'(1);
      end
      if (cmd.drain_init) begin
         drain_in = '0;
      end
      if (cmd.drain_issue) begin
         drain_in = drain_ff + WCNT_W'(1);
      end

      if (cmd.start_play) begin
         rp_in     = START_PTR;
         delay_in  = 7'd1;
         loops_in  = loop_count_ff;
         resume_in = 1'b0;
         ym_in     = 6'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff         <= '0;
         delay_ff      <= '0;
         loops_ff      <= '0;
         resume_ff     <= 1'b0;
         ym_ff         <= '0;
         loop_count_ff <= LOOP_COUNT_RESET;
         wcnt_ff       <= '0;
         budget_ff     <= '0;
         paused_ff     <= 1'b0;
         drain_ff      <= '0;
         s1_write_ff   <= 1'b0;
         s1_stat_ff    <= 1'b0;
         strobe_ff     <= 1'b0;
      end else begin
         rp_ff         <= rp_in;
         delay_ff      <= delay_in;
         loops_ff      <= loops_in;
         resume_ff     <= resume_in;
         ym_ff         <= ym_in;
         loop_count_ff <= loop_count_in;
         wcnt_ff       <= wcnt_in;
         budget_ff     <= budget_in;
         paused_ff     <= paused_in;
         drain_ff      <= drain_in;
         s1_write_ff   <= cmd.drain_issue;
         s1_stat_ff    <= cmd.stat_issue;
         strobe_ff     <= s1_write_ff | s1_stat_ff;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.op_latch) begin
         op_ff <= mem_q_ff;
      end
      if (cmd.lb0_latch) begin
         lb0_ff <= mem_q_ff;
      end
      if (cmd.lb1_latch) begin
         lb1_ff <= mem_q_ff;
      end
      if (cmd.fin_latch) begin
         playing_ff <= (delay_ff != 7'd0) || resume_ff;
         more_ff    <= paused_ff;
      end
      if (s1_write_ff || s1_stat_ff) begin
         wv_ff          <= s1_write_ff;
         chip_ff        <= s1_write_ff & buf_q_ff.chip;
         reg_index_ff   <= s1_write_ff ? buf_q_ff.reg_index : 8'd0;
         reg_value_ff   <= s1_write_ff ? buf_q_ff.reg_value : 8'd0;
         last_ff        <= s1_stat_ff;
         rsp_playing_ff <= playing_ff;
         rsp_more_ff    <= more_ff;
      end
   end

   always_comb begin
      status.resume      = resume_ff;
      status.delay_zero  = (delay_ff == 7'd0);
      status.delay_one   = (delay_ff == 7'd1);
      status.ym_zero     = (ym_ff == 6'd0);
      status.budget_zero = (budget_ff == '0);
      status.writes_full = (wcnt_ff == WCNT_W'(MAX_WRITES));
      status.op_class    = classify(mem_q_ff);
      status.loops_zero  = (loops_ff == 8'd0);
      status.laddr_zero  = ({mem_q_ff, lb1_ff, lb0_ff} == 24'd0);
      status.count_zero  = (wcnt_ff == '0);
      status.drain_last  = (drain_ff == (wcnt_ff - WCNT_W'(1)));
   end

   assign csr_ready        = 1'b1;
   assign rsp_strobe       = strobe_ff;
   assign rsp_write_valid  = wv_ff;
   assign rsp_chip         = chip_ff;
   assign rsp_reg_index    = reg_index_ff;
   assign rsp_reg_value    = reg_value_ff;
   assign rsp_playing      = rsp_playing_ff;
   assign rsp_more_pending = rsp_more_ff;
   assign rsp_last         = last_ff;

endmodule

// ===== design/mcsp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcsp_ctrl
// Controller: sequences request handling, command decoding and result output.
// ----------------------------------------------------------------------------
module mcsp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [1:0]              req_cmd,
   input  mcsp_pkg::dp_status_type status,
   output logic                    busy,
   output mcsp_pkg::ctrl_cmd_type  cmd
);
   import mcsp_pkg::*;

   typedef enum logic [13:0] {
      S_IDLE    = 14'h0001,
      S_TICK    = 14'h0002,
      S_DEC     = 14'h0004,
      S_OP      = 14'h0008,
      S_PSG_VAL = 14'h0010,
      S_EXT_LEN = 14'h0020,
      S_YM_REG  = 14'h0040,
      S_YM_VAL  = 14'h0080,
      S_END_B0  = 14'h0100,
      S_END_B1  = 14'h0200,
      S_END_B2  = 14'h0400,
      S_FIN     = 14'h0800,
      S_DRAIN   = 14'h1000,
      S_STAT    = 14'h2000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd        = '0;
      cmd.rd_sel = RD_PTR;
      cmd.ptr_op = PTR_HOLD;
      state_in   = state_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (req_cmd)
                  CMD_LOAD:  cmd.load_wr    = 1'b1;
                  CMD_START: cmd.start_play = 1'b1;
                  CMD_TICK:  state_in       = S_TICK;
                  default:   state_in       = S_IDLE;
               endcase
            end
         end
         S_TICK: begin
            cmd.tick_init = 1'b1;
            priority if (status.resume) begin
               state_in = S_DEC;
            end else if (!status.delay_zero) begin
               cmd.delay_dec = 1'b1;
               state_in      = status.delay_one ? S_DEC : S_FIN;
            end else begin
               state_in = S_FIN;
            end
         end
         S_DEC: begin
            // An unfinished YM run takes precedence over fetching a new command.
            priority if (!status.ym_zero) begin
               if (status.writes_full) begin
                  cmd.pause = 1'b1;
                  state_in  = S_FIN;
               end else begin
                  state_in = S_YM_REG;
               end
            end else if (status.budget_zero) begin
               cmd.pause = 1'b1;
               state_in  = S_FIN;
            end else begin
               cmd.budget_dec = 1'b1;
               state_in       = S_OP;
            end
         end
         S_OP: begin
            cmd.op_latch = 1'b1;
            unique case (status.op_class)
               OPC_PSG: begin
                  if (status.writes_full) begin
                     cmd.pause = 1'b1;
                     state_in  = S_FIN;
                  end else begin
                     cmd.rd_sel = RD_PTR1;
                     state_in   = S_PSG_VAL;
                  end
               end
               OPC_EXT: begin
                  cmd.rd_sel = RD_PTR1;
                  state_in   = S_EXT_LEN;
               end
               OPC_YM: begin
                  cmd.ym_load = 1'b1;
                  cmd.ptr_op  = PTR_ADD1;
                  state_in    = S_DEC;
               end
               OPC_END: begin
                  cmd.loops_dec = 1'b1;
                  cmd.rd_sel    = RD_LOOP0;
                  state_in      = S_END_B0;
               end
               OPC_DELAY: begin
                  cmd.delay_set = 1'b1;
                  cmd.ptr_op    = PTR_ADD1;
                  cmd.finish    = 1'b1;
                  state_in      = S_FIN;
               end
               default: begin
                  state_in = S_FIN;
               end
            endcase
         end
         S_PSG_VAL: begin
            cmd.push   = 1'b1;
            cmd.ptr_op = PTR_ADD2;
            state_in   = S_DEC;
         end
         S_EXT_LEN: begin
            cmd.ptr_op = PTR_ADD_EXT;
            state_in   = S_DEC;
         end
         S_YM_REG: begin
            cmd.op_latch = 1'b1;
            cmd.rd_sel   = RD_PTR1;
            state_in     = S_YM_VAL;
         end
         S_YM_VAL: begin
            cmd.push    = 1'b1;
            cmd.push_ym = 1'b1;
            cmd.ptr_op  = PTR_ADD2;
            cmd.ym_dec  = 1'b1;
            state_in    = S_DEC;
         end
         S_END_B0: begin
            cmd.lb0_latch = 1'b1;
            cmd.rd_sel    = RD_LOOP1;
            state_in      = S_END_B1;
         end
         S_END_B1: begin
            cmd.lb1_latch = 1'b1;
            cmd.rd_sel    = RD_LOOP2;
            state_in      = S_END_B2;
         end
         S_END_B2: begin
            if (!status.loops_zero && !status.laddr_zero) begin
               cmd.ptr_op = PTR_LOOP;
               state_in   = S_DEC;
            end else begin
               cmd.delay_clear = 1'b1;
               cmd.finish      = 1'b1;
               state_in        = S_FIN;
            end
         end
         S_FIN: begin
            cmd.fin_latch  = 1'b1;
            cmd.drain_init = 1'b1;
            state_in       = status.count_zero ? S_STAT : S_DRAIN;
         end
         S_DRAIN: begin
            cmd.drain_issue = 1'b1;
            if (status.drain_last) begin
               state_in = S_STAT;
            end
         end
         S_STAT: begin
            cmd.stat_issue = 1'b1;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ===== design/music_command_stream_player.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// music_command_stream_player
// Plays a loaded command stream, one timer tick at a time, as chip writes.
// ----------------------------------------------------------------------------
//  Channel   Ports                                   Transfer
//  request   start, busy, req_cmd/address/data       start high while busy low
//  result    rsp_strobe, rsp_*                       every cycle rsp_strobe is high
//  config    csr_valid, csr_ready, csr_loop_count    csr_valid and csr_ready high
//
// A load or a start is done without leaving idle, so busy stays low. A tick keeps
// busy high while it decodes the commands that are due, paced by the single read
// port of the song memory, and then issues one result per buffered write and a
// closing status item. Each result issued by the controller passes s1_write_ff or
// s1_stat_ff and then the output registers, so the closing status item appears
// after busy falls. The receiver cannot stall. Reset is synchronous; the song
// memory is not cleared.
// ----------------------------------------------------------------------------
module music_command_stream_player (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_data,
   output logic        rsp_strobe,
   output logic        rsp_write_valid,
   output logic        rsp_chip,
   output logic [7:0]  rsp_reg_index,
   output logic [7:0]  rsp_reg_value,
   output logic        rsp_playing,
   output logic        rsp_more_pending,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_loop_count
);
   import mcsp_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   mcsp_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_cmd),
      .status  (status),
      .busy    (busy),
      .cmd     (cmd)
   );

   mcsp_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_address      (req_address),
      .req_data         (req_data),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_loop_count   (csr_loop_count),
      .rsp_strobe       (rsp_strobe),
      .rsp_write_valid  (rsp_write_valid),
      .rsp_chip         (rsp_chip),
      .rsp_reg_index    (rsp_reg_index),
      .rsp_reg_value    (rsp_reg_value),
      .rsp_playing      (rsp_playing),
      .rsp_more_pending (rsp_more_pending),
      .rsp_last         (rsp_last)
   );

endmodule
